>>> rtl/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants for the top-k cosine similarity search block.
// ----------------------------------------------------------------------------
package cts_pkg;
	localparam int MAX_DIM      = 4096;
	localparam int MAX_TOPK     = 16;
	localparam int ELEMENT_BITS = 16;
	localparam int ACC_BITS     = 44;
	localparam int IDX_BITS     = 12;
	localparam int CNT_BITS     = 13;
	localparam int TAG_BITS     = 32;
	localparam int RANK_BITS    = 4;
	localparam int ROOT_BITS    = 22;
	localparam int DEN_BITS     = 44;
	localparam int NUM_BITS     = 59;
	localparam logic [CNT_BITS-1:0] COUNT_MAX = 13'd8191;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CAND   = 2'd2,
		OP_REPORT = 2'd3
	} op_t;

	typedef enum logic {
		REG_TOPK = 1'b0,
		REG_VLEN = 1'b1
	} reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_SCORE,
		ST_INSERT,
		ST_REPORT
	} state_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_SQRT,
		SC_MUL,
		SC_DIV,
		SC_SAT
	} score_state_t;

	typedef struct packed {
		logic                    start;
		logic [ACC_BITS-1:0]     dot;
		logic [ACC_BITS-1:0]     qsum;
		logic [ACC_BITS-1:0]     csum;
	} score_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [15:0]      score;
	} score_rsp_t;
endpackage

>>> rtl/cts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/cts_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_score
// Iterative cosine score: two bit-pair square roots, one 22x22 multiply,
// then a restoring divide one quotient bit per cycle, then saturation.
// ----------------------------------------------------------------------------
module cts_score (
	input  logic                clk,
	input  logic                arst_n,
	input  cts_pkg::score_req_t req,
	output cts_pkg::score_rsp_t rsp
);
	import cts_pkg::*;

	score_state_t          st_q, st_d;
	logic [5:0]            cnt_q;
	logic [ACC_BITS-1:0]   xq_q, xc_q;
	logic [ROOT_BITS-1:0]  rq_q, rc_q;
	logic [ACC_BITS+1:0]   remq_q, remc_q;
	logic                  neg_q;
	logic [NUM_BITS-1:0]   num_q;
	logic [DEN_BITS-1:0]   den_q;
	logic [DEN_BITS:0]     drem_q;
	logic [NUM_BITS-1:0]   quo_q;
	logic                  zero_q;
	logic signed [15:0]    score_q;
	logic                  done_q;

	logic [ACC_BITS+1:0]   trq, trc, nremq, nremc;
	logic [ROOT_BITS-1:0]  nrq, nrc;
	logic [DEN_BITS:0]     dsh;
	logic [ACC_BITS-1:0]   mag;

	// one root bit per cycle for both norms
	always_comb begin
		nremq = {remq_q[ACC_BITS-1:0], xq_q[ACC_BITS-1 -: 2]};
		trq   = {{(ACC_BITS+2-ROOT_BITS-2){1'b0}}, rq_q, 2'b01};
		nrq   = {rq_q[ROOT_BITS-2:0], 1'b0};
		if (nremq >= trq) begin
			nremq = nremq - trq;
			nrq[0] = 1'b1;
		end
		nremc = {remc_q[ACC_BITS-1:0], xc_q[ACC_BITS-1 -: 2]};
		trc   = {{(ACC_BITS+2-ROOT_BITS-2){1'b0}}, rc_q, 2'b01};
		nrc   = {rc_q[ROOT_BITS-2:0], 1'b0};
		if (nremc >= trc) begin
			nremc = nremc - trc;
			nrc[0] = 1'b1;
		end
		dsh = {drem_q[DEN_BITS-1:0], num_q[NUM_BITS-1]};
		mag = req.dot[ACC_BITS-1] ? (~req.dot + 1'b1) : req.dot;
	end

	// sequencer next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			SC_IDLE: if (req.start) begin
				st_d = SC_SQRT;
			end
			SC_SQRT: if (cnt_q == 6'd0) begin
				st_d = SC_MUL;
			end
			SC_MUL:  st_d = zero_q ? SC_SAT : SC_DIV;
			SC_DIV:  if (cnt_q == 6'd0) begin
				st_d = SC_SAT;
			end
			SC_SAT:  st_d = SC_IDLE;
			default: st_d = SC_IDLE;
		endcase
	end

	// sequencer state and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SC_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == SC_SAT);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			SC_IDLE: begin
				xq_q   <= req.qsum;
				xc_q   <= req.csum;
				rq_q   <= '0;
				rc_q   <= '0;
				remq_q <= '0;
				remc_q <= '0;
				cnt_q  <= 6'(ACC_BITS/2 - 1);
				neg_q  <= req.dot[ACC_BITS-1];
				num_q  <= {mag, 15'd0};
				zero_q <= (req.qsum == '0) || (req.csum == '0);
			end
			SC_SQRT: begin
				xq_q   <= {xq_q[ACC_BITS-3:0], 2'b00};
				xc_q   <= {xc_q[ACC_BITS-3:0], 2'b00};
				remq_q <= nremq;
				remc_q <= nremc;
				rq_q   <= nrq;
				rc_q   <= nrc;
				cnt_q  <= cnt_q - 6'd1;
			end
			SC_MUL: begin
				den_q  <= {{(DEN_BITS-ROOT_BITS){1'b0}}, rq_q}
					* {{(DEN_BITS-ROOT_BITS){1'b0}}, rc_q};
				drem_q <= '0;
				quo_q  <= '0;
				cnt_q  <= 6'(NUM_BITS - 1);
			end
			SC_DIV: begin
				if (dsh >= {1'b0, den_q}) begin
					drem_q <= dsh - {1'b0, den_q};
					quo_q  <= {quo_q[NUM_BITS-2:0], 1'b1};
				end else begin
					drem_q <= dsh;
					quo_q  <= {quo_q[NUM_BITS-2:0], 1'b0};
				end
				num_q <= {num_q[NUM_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
			end
			SC_SAT: begin
				if (zero_q) begin
					score_q <= 16'sh8000;
				end else if (neg_q) begin
					score_q <= (quo_q >= NUM_BITS'(32768)) ? 16'sh8000
						: 16'(-quo_q[15:0]);
				end else begin
					score_q <= (quo_q >= NUM_BITS'(32767)) ? 16'sh7fff
						: 16'(quo_q[15:0]);
				end
			end
			default: ;
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.score = score_q;
endmodule

>>> rtl/cosine_topk_similarity_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_topk_similarity_search_top
// Streams query and candidate elements, scores each candidate by cosine
// similarity and keeps a sorted top-k hit list.
// ----------------------------------------------------------------------------
//  channel | handshake        | payload
//  in      | in_valid/in_stall| operation, element_index, element_value,
//          |                  | last_element, candidate_tag, has_content
//  out     | out_valid/out_stall | hit_rank, hit_tag, hit_score, last_hit
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Query writes and clear are taken while idle; a candidate element goes
// through a query RAM read, then a multiply-accumulate. The last element of a
// matching candidate with content then goes through scoring (square roots,
// multiply, divide and saturate; the divide is skipped when a norm is zero)
// and the insert scan. A report holds the input until every kept hit is
// sent, longer while out_stall is high.
// Reset empties the list and clears accumulators; the query RAM is not cleared.
module cosine_topk_similarity_search_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             operation,
	input  logic [cts_pkg::IDX_BITS-1:0]           element_index,
	input  logic signed [cts_pkg::ELEMENT_BITS-1:0] element_value,
	input  logic                                   last_element,
	input  logic [cts_pkg::TAG_BITS-1:0]           candidate_tag,
	input  logic                                   has_content,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [cts_pkg::RANK_BITS-1:0]          hit_rank,
	output logic [cts_pkg::TAG_BITS-1:0]           hit_tag,
	output logic signed [15:0]                     hit_score,
	output logic                                   last_hit,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic                                   cfg_index,
	input  logic [12:0]                            cfg_data
);
	import cts_pkg::*;

	state_t                  st_q, st_d;
	logic [4:0]              topk_q;
	logic [CNT_BITS-1:0]     vlen_q;
	logic [ACC_BITS-1:0]     dot_q, qsum_q, csum_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic signed [15:0]      cval_s1;
	logic                    acc_s1, last_s1, content_s1;
	logic [CNT_BITS-1:0]     cnt_s1;
	logic [TAG_BITS-1:0]     tag_q;
	logic signed [15:0]      hsc_q [MAX_TOPK];
	logic [TAG_BITS-1:0]     htag_q [MAX_TOPK];
	logic [MAX_TOPK-1:0]     hval_q;
	logic [4:0]              pos_q;
	logic signed [15:0]      new_sc_q;
	logic [ELEMENT_BITS-1:0] qrd;
	logic                    in_acc;
	logic [4:0]              k_eff;
	score_req_t              sreq;
	score_rsp_t              srsp;
	logic signed [31:0]      qq, qc, cc;
	logic [RANK_BITS-1:0]    rank_q;
	logic                    ins_hit;
	logic [4:0]              nxt;

	assign cfg_ready = (st_q == ST_IDLE);
	assign in_stall  = (st_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign k_eff     = (topk_q > 5'(MAX_TOPK)) ? 5'(MAX_TOPK) : topk_q;

	// query memory
	cts_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(MAX_DIM)) u_qram (
		.clk   (clk),
		.we    (in_acc && operation == OP_QUERY),
		.waddr (element_index),
		.wdata (element_value),
		.raddr (element_index),
		.rdata (qrd)
	);

	cts_score u_score (.clk(clk), .arst_n(arst_n), .req(sreq), .rsp(srsp));

	assign sreq.start = (st_q == ST_SCORE) && !srsp.done;
	assign sreq.dot   = dot_q;
	assign sreq.qsum  = qsum_q;
	assign sreq.csum  = csum_q;

	// multiply products for the accumulate stage
	always_comb begin
		qq = $signed(qrd) * $signed(qrd);
		qc = $signed(qrd) * cval_s1;
		cc = cval_s1 * cval_s1;
	end

	// next report slot at or after rank_q
	always_comb begin
		nxt = 5'(MAX_TOPK);
		for (int i = MAX_TOPK - 1; i >= 0; i--) begin
			if (hval_q[i] && 5'(i) >= {1'b0, rank_q} && 5'(i) < k_eff) begin
				nxt = 5'(i);
			end
		end
	end

	// insert position test at pos_q
	assign ins_hit = !hval_q[pos_q[3:0]] || (new_sc_q > hsc_q[pos_q[3:0]]);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_acc) begin
				if (operation == OP_CAND) begin
					st_d = ST_ACC;
				end else if (operation == OP_REPORT) begin
					st_d = ST_REPORT;
				end
			end
			ST_ACC: begin
				if (last_s1 && cnt_s1 == vlen_q && content_s1 && k_eff != 5'd0) begin
					st_d = ST_SCORE;
				end else begin
					st_d = ST_IDLE;
				end
			end
			ST_SCORE: if (srsp.done) begin
				st_d = ST_INSERT;
			end
			ST_INSERT: if (pos_q >= k_eff || ins_hit) begin
				st_d = ST_IDLE;
			end
			ST_REPORT: if (nxt == 5'(MAX_TOPK) || (out_valid && !out_stall && last_hit)) begin
				if (!out_valid || (!out_stall && last_hit) || nxt == 5'(MAX_TOPK)) begin
					st_d = (out_valid && out_stall) ? ST_REPORT : ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topk_q <= 5'd8;
			vlen_q <= 13'd768;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TOPK: topk_q <= cfg_data[4:0];
				REG_VLEN: vlen_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// accumulators and element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q  <= '0;
			qsum_q <= '0;
			csum_q <= '0;
			cnt_q  <= '0;
			cval_s1 <= '0;
			acc_s1 <= 1'b0;
			last_s1 <= 1'b0;
			content_s1 <= 1'b0;
			tag_q  <= '0;
			cnt_s1 <= '0;
		end else begin
			if (in_acc && operation == OP_CAND) begin
				cval_s1    <= element_value;
				acc_s1     <= cnt_q < vlen_q;
				last_s1    <= last_element;
				content_s1 <= has_content;
				tag_q      <= candidate_tag;
				cnt_s1     <= (cnt_q < COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
				cnt_q      <= (cnt_q < COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
			end
			if (st_q == ST_ACC) begin
				if (acc_s1) begin
					dot_q  <= dot_q + ACC_BITS'(qc);
					qsum_q <= qsum_q + ACC_BITS'(qq);
					csum_q <= csum_q + ACC_BITS'(cc);
				end
				if (last_s1) begin
					cnt_q <= '0;
				end
			end
			if ((st_q == ST_ACC && last_s1 && st_d == ST_IDLE)
				|| (st_q == ST_INSERT && st_d == ST_IDLE)) begin
				dot_q  <= '0;
				qsum_q <= '0;
				csum_q <= '0;
			end
		end
	end

	// hit list: one slot tested per cycle; shift and insert in the same cycle as the winning test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hval_q   <= '0;
			pos_q    <= '0;
			new_sc_q <= '0;
			for (int i = 0; i < MAX_TOPK; i++) begin
				hsc_q[i]  <= '0;
				htag_q[i] <= '0;
			end
		end else begin
			if (in_acc && operation == OP_CLEAR) begin
				hval_q <= '0;
			end
			if (st_q == ST_SCORE) begin
				pos_q    <= '0;
				new_sc_q <= srsp.score;
			end
			if (st_q == ST_INSERT) begin
				if (pos_q < k_eff && ins_hit) begin
					for (int i = MAX_TOPK - 1; i > 0; i--) begin
						if (5'(i) > pos_q && 5'(i) < k_eff) begin
							hsc_q[i]  <= hsc_q[i-1];
							htag_q[i] <= htag_q[i-1];
							hval_q[i] <= hval_q[i-1];
						end
					end
					hsc_q[pos_q[3:0]]  <= new_sc_q;
					htag_q[pos_q[3:0]] <= tag_q;
					hval_q[pos_q[3:0]] <= 1'b1;
				end else begin
					pos_q <= pos_q + 5'd1;
				end
			end
		end
	end

	// report output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			rank_q    <= '0;
			hit_rank  <= '0;
			hit_tag   <= '0;
			hit_score <= '0;
			last_hit  <= 1'b0;
		end else begin
			if (in_acc && operation == OP_REPORT) begin
				rank_q <= '0;
			end else if (st_q == ST_REPORT && (!out_valid || !out_stall)) begin
				if (out_valid && last_hit) begin
					out_valid <= 1'b0;
				end else if (nxt != 5'(MAX_TOPK)) begin
					out_valid <= 1'b1;
					hit_rank  <= nxt[3:0];
					hit_tag   <= htag_q[nxt[3:0]];
					hit_score <= hsc_q[nxt[3:0]];
					rank_q    <= nxt[3:0] + 1'b1;
					last_hit  <= (nxt[3:0] == 4'd15);
					for (int j = 0; j < MAX_TOPK; j++) begin
						if (5'(j) > nxt && 5'(j) < k_eff && hval_q[j]) begin
							last_hit <= 1'b0;
						end
					end
					if (nxt[3:0] != 4'd15) begin
						last_hit <= 1'b1;
						for (int j = 0; j < MAX_TOPK; j++) begin
							if (5'(j) > nxt && 5'(j) < k_eff && hval_q[j]) begin
								last_hit <= 1'b0;
							end
						end
					end
				end else begin
					out_valid <= 1'b0;
				end
			end
		end
	end

	// checks
	a_no_in_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> in_stall) else $error("input taken while busy");
	a_out_only_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (st_q == ST_REPORT || st_q == ST_IDLE)) else $error("stray result");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> (st_q == ST_IDLE)) else $error("cfg while busy");
	a_score_done: assert property (@(posedge clk) disable iff (!arst_n)
		srsp.done |-> (st_q == ST_SCORE)) else $error("score outside scoring");
endmodule
